[rtl/core/generational_slot_allocator_defines.svh]
// Assertion macros for the generational slot allocator.
// Used by modules that assert; expects clk and arst_n in scope.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GSA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define GSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/gsa_pkg.sv]
// Shared types, codes and helpers for the generational slot allocator.
// No dependencies.
package gsa_pkg;

	localparam int WORD_BITS = 64;
	localparam int BIT_AW = 6;
	localparam int SLOT_COUNT_DEF = 1024;
	localparam int GEN_BITS_DEF = 16;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_CHECK = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_INVALID = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_AGEN,
		ST_HRD,
		ST_HEVAL,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] idx;
		logic [15:0] gen;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] idx;
		logic [15:0] gen;
	} res_t;

	// Position of the lowest set bit: isolate it, then encode the one-hot word.
	function automatic logic [BIT_AW-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
		logic [WORD_BITS-1:0] onehot;
		logic [BIT_AW-1:0] n;
		onehot = w & (~w + {{(WORD_BITS-1){1'b0}}, 1'b1});
		n = '0;
		for (int k = 0; k < BIT_AW; k++) begin
			for (int j = 0; j < WORD_BITS; j++) begin
				if (j[k])
					n[k] = n[k] | onehot[j];
			end
		end
		return n;
	endfunction

endpackage

[rtl/core/gsa_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module gsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/gsa_ctrl.sv]
// Sequencer for the slot allocator: clearing pass, free-map scan, handle checks.
// Depends on gsa_pkg and generational_slot_allocator_defines.svh.
`include "generational_slot_allocator_defines.svh"

module gsa_ctrl #(
	parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF,
	parameter int GEN_BITS = gsa_pkg::GEN_BITS_DEF,
	localparam int WORD_COUNT = (SLOT_COUNT + gsa_pkg::WORD_BITS - 1) / gsa_pkg::WORD_BITS,
	localparam int WAW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1,
	localparam int SAW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  gsa_pkg::req_t                  req,
	input  logic                           out_space,
	output logic                           res_push,
	output gsa_pkg::res_t                  res,
	output logic                           fm_we,
	output logic [WAW-1:0]                 fm_waddr,
	output logic [gsa_pkg::WORD_BITS-1:0]  fm_wdata,
	output logic [WAW-1:0]                 fm_raddr,
	input  logic [gsa_pkg::WORD_BITS-1:0]  fm_rdata,
	output logic                           gen_we,
	output logic [SAW-1:0]                 gen_waddr,
	output logic [GEN_BITS-1:0]            gen_wdata,
	output logic [SAW-1:0]                 gen_raddr,
	input  logic [GEN_BITS-1:0]            gen_rdata
);

	localparam int WB = gsa_pkg::WORD_BITS;
	localparam int BW = gsa_pkg::BIT_AW;
	localparam int GCW = (GEN_BITS > 16) ? GEN_BITS : 16;
	localparam int REM = SLOT_COUNT % WB;
	localparam logic [WB-1:0] LAST_MASK = (REM == 0) ? {WB{1'b1}} :
		((WB'(1) << REM) - WB'(1));
	localparam logic [WAW:0] WC_W = (WAW+1)'(WORD_COUNT);
	localparam logic [WAW-1:0] LAST_WORD = WAW'(WORD_COUNT - 1);
	localparam logic [SAW-1:0] LAST_SLOT = SAW'(SLOT_COUNT - 1);
	localparam logic [SAW:0] WC_S = (SAW+1)'(WORD_COUNT);
	localparam logic [SAW-1:0] LAST_WORD_S = SAW'(WORD_COUNT - 1);
	localparam logic [16:0] SC_17 = 17'(SLOT_COUNT);
	localparam logic [GEN_BITS-1:0] GEN_ONE = GEN_BITS'(1);

	gsa_pkg::state_t state_q, state_d;
	logic [WAW-1:0] search_q, search_d;
	logic [WAW-1:0] ptr_q, ptr_d;
	logic [WAW-1:0] addr_s1, addr_d;
	logic           pend_q, pend_d;
	logic [WAW-1:0] chk_cnt_q, chk_d;
	logic [SAW-1:0] init_q, init_d;
	gsa_pkg::req_t  req_q, req_d;
	gsa_pkg::res_t  res_q, res_d;
	logic [15:0]    gidx_q, gidx_d;

	logic [WB-1:0]       onehot;
	logic [BW-1:0]       bit_pos;
	logic [WAW+BW-1:0]   found_slot;
	logic [WAW-1:0]      h_word;
	logic [BW-1:0]       h_bit;
	logic                h_valid;
	logic [GEN_BITS-1:0] gen_inc;

	assign onehot = fm_rdata & (~fm_rdata + WB'(1));
	assign bit_pos = gsa_pkg::lowest_set(fm_rdata);
	assign found_slot = {addr_s1, bit_pos};
	assign h_word = WAW'(req_q.idx >> BW);
	assign h_bit = req_q.idx[BW-1:0];
	assign h_valid = ({1'b0, req_q.idx} < SC_17) &&
		(GCW'(gen_rdata) == GCW'(req_q.gen)) && !fm_rdata[h_bit];

	always_comb begin
		gen_inc = gen_rdata + GEN_ONE;
		if (gen_inc == '0)
			gen_inc = GEN_ONE;
	end

	always_comb begin
		state_d = state_q;
		search_d = search_q;
		ptr_d = ptr_q;
		addr_d = addr_s1;
		pend_d = 1'b0;
		chk_d = chk_cnt_q;
		init_d = init_q;
		req_d = req_q;
		res_d = res_q;
		gidx_d = gidx_q;
		in_ready = 1'b0;
		res_push = 1'b0;
		fm_we = 1'b0;
		fm_waddr = addr_s1;
		fm_wdata = fm_rdata;
		fm_raddr = ptr_q;
		gen_we = 1'b0;
		gen_waddr = init_q;
		gen_wdata = GEN_ONE;
		gen_raddr = SAW'(req_q.idx);
		case (state_q)
			gsa_pkg::ST_INIT: begin
				gen_we = 1'b1;
				if ({1'b0, init_q} < WC_S) begin
					fm_we = 1'b1;
					fm_waddr = WAW'(init_q);
					fm_wdata = (init_q == LAST_WORD_S) ? LAST_MASK : {WB{1'b1}};
				end
				if (init_q == LAST_SLOT)
					state_d = gsa_pkg::ST_IDLE;
				else
					init_d = init_q + SAW'(1);
			end
			gsa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					req_d = req;
					case (req.op)
						gsa_pkg::OP_ALLOC: begin
							ptr_d = search_q;
							chk_d = '0;
							state_d = gsa_pkg::ST_SCAN;
						end
						gsa_pkg::OP_FREE,
						gsa_pkg::OP_CHECK: begin
							state_d = gsa_pkg::ST_HRD;
						end
						default: begin
							res_d = '{status: gsa_pkg::STAT_INVALID, idx: '0, gen: '0};
							state_d = gsa_pkg::ST_DONE;
						end
					endcase
				end
			end
			gsa_pkg::ST_SCAN: begin
				// one word read per cycle; data of the previous address is checked
				if (pend_q && fm_rdata != '0) begin
					fm_we = 1'b1;
					fm_waddr = addr_s1;
					fm_wdata = fm_rdata & ~onehot;
					search_d = addr_s1;
					gidx_d = 16'(found_slot);
					gen_raddr = SAW'(found_slot);
					state_d = gsa_pkg::ST_AGEN;
				end else if (pend_q && chk_cnt_q == LAST_WORD) begin
					res_d = '{status: gsa_pkg::STAT_EMPTY, idx: '0, gen: '0};
					state_d = gsa_pkg::ST_DONE;
				end else begin
					pend_d = 1'b1;
					addr_d = ptr_q;
					ptr_d = (ptr_q == LAST_WORD) ? '0 : ptr_q + WAW'(1);
					chk_d = chk_cnt_q + WAW'(pend_q);
				end
			end
			gsa_pkg::ST_AGEN: begin
				res_d = '{status: gsa_pkg::STAT_OK, idx: gidx_q, gen: 16'(gen_rdata)};
				state_d = gsa_pkg::ST_DONE;
			end
			gsa_pkg::ST_HRD: begin
				fm_raddr = h_word;
				gen_raddr = SAW'(req_q.idx);
				state_d = gsa_pkg::ST_HEVAL;
			end
			gsa_pkg::ST_HEVAL: begin
				if (h_valid && req_q.op == gsa_pkg::OP_FREE) begin
					gen_we = 1'b1;
					gen_waddr = SAW'(req_q.idx);
					gen_wdata = gen_inc;
					fm_we = 1'b1;
					fm_waddr = h_word;
					fm_wdata = fm_rdata | (WB'(1) << h_bit);
				end
				res_d = '{status: h_valid ? gsa_pkg::STAT_OK : gsa_pkg::STAT_INVALID,
					idx: '0, gen: '0};
				state_d = gsa_pkg::ST_DONE;
			end
			gsa_pkg::ST_DONE: begin
				if (out_space) begin
					res_push = 1'b1;
					state_d = gsa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gsa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gsa_pkg::ST_INIT;
			search_q <= '0;
			ptr_q <= '0;
			pend_q <= 1'b0;
			chk_cnt_q <= '0;
			init_q <= '0;
		end else begin
			state_q <= state_d;
			search_q <= search_d;
			ptr_q <= ptr_d;
			pend_q <= pend_d;
			chk_cnt_q <= chk_d;
			init_q <= init_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_d;
		req_q <= req_d;
		res_q <= res_d;
		gidx_q <= gidx_d;
	end

	assign res = res_q;

	`GSA_ASSERT_SAME(a_gen_nonzero, gen_we, gen_wdata != '0, "generation written as zero")
	`GSA_ASSERT_SAME(a_scan_one_bit, state_q == gsa_pkg::ST_SCAN && fm_we, $countones(fm_rdata ^ fm_wdata) == 1, "allocate changed other than one bit")
	`GSA_ASSERT_SAME(a_cursor_range, 1'b1, {1'b0, search_q} < WC_W, "search cursor past word count")
	`GSA_ASSERT_NEXT(a_init_once, state_q != gsa_pkg::ST_INIT, state_q != gsa_pkg::ST_INIT, "clearing pass reentered")
	`GSA_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_q != gsa_pkg::ST_IDLE, "accepted word left controller idle")

endmodule

[rtl/core/generational_slot_allocator.sv]
// Top level of the generational slot allocator: controller, free-map and
// generation RAMs, output register. Depends on gsa_pkg, gsa_ram, gsa_ctrl.
//
// Channel  Dir  tdata                                      tuser
// s_axis   in   [15:0] slot_index, [31:16] handle_generation [1:0] operation
// m_axis   out  [15:0] granted_index, [31:16] granted_generation [1:0] status
//
// After reset a clearing pass writes every generation entry (and every free-map
// word) once, with s_axis_tready low.
// Free and check read the free-map word and generation entry, then evaluate the
// handle; an invalid operation goes straight to the result. Allocate reads words
// through the single free-map read port until a free bit is found, and reports empty
// when none of the WORD_COUNT (WORD_COUNT = ceil(SLOT_COUNT/64)) words has one.
// One word is worked on at a time; the next is taken while a result waits in
// the output register, and a full output register holds the controller.
module generational_slot_allocator #(
	parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF,
	parameter int GEN_BITS = gsa_pkg::GEN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] slot_index, [31:16] handle_generation
	input  logic [1:0]  s_axis_tuser,  // [1:0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [15:0] granted_index, [31:16] granted_generation
	output logic [1:0]  m_axis_tuser   // [1:0] status
);

	localparam int WB = gsa_pkg::WORD_BITS;
	localparam int WORD_COUNT = (SLOT_COUNT + WB - 1) / WB;
	localparam int WAW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int SAW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	gsa_pkg::req_t req;
	gsa_pkg::res_t res;
	gsa_pkg::res_t out_q;
	logic          out_valid_q;
	logic          out_space;
	logic          res_push;

	logic                fm_we;
	logic [WAW-1:0]      fm_waddr;
	logic [WB-1:0]       fm_wdata;
	logic [WAW-1:0]      fm_raddr;
	logic [WB-1:0]       fm_rdata;
	logic                gen_we;
	logic [SAW-1:0]      gen_waddr;
	logic [GEN_BITS-1:0] gen_wdata;
	logic [SAW-1:0]      gen_raddr;
	logic [GEN_BITS-1:0] gen_rdata;

	assign req = '{op: gsa_pkg::op_t'(s_axis_tuser), idx: s_axis_tdata[15:0],
		gen: s_axis_tdata[31:16]};
	assign out_space = !out_valid_q || m_axis_tready;

	gsa_ctrl #(
		.SLOT_COUNT(SLOT_COUNT),
		.GEN_BITS(GEN_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.req(req),
		.out_space(out_space),
		.res_push(res_push),
		.res(res),
		.fm_we(fm_we),
		.fm_waddr(fm_waddr),
		.fm_wdata(fm_wdata),
		.fm_raddr(fm_raddr),
		.fm_rdata(fm_rdata),
		.gen_we(gen_we),
		.gen_waddr(gen_waddr),
		.gen_wdata(gen_wdata),
		.gen_raddr(gen_raddr),
		.gen_rdata(gen_rdata)
	);

	gsa_ram #(
		.WIDTH(WB),
		.DEPTH(WORD_COUNT)
	) u_free_map (
		.clk(clk),
		.we(fm_we),
		.waddr(fm_waddr),
		.wdata(fm_wdata),
		.raddr(fm_raddr),
		.rdata(fm_rdata)
	);

	gsa_ram #(
		.WIDTH(GEN_BITS),
		.DEPTH(SLOT_COUNT)
	) u_gen_ram (
		.clk(clk),
		.we(gen_we),
		.waddr(gen_waddr),
		.wdata(gen_wdata),
		.raddr(gen_raddr),
		.rdata(gen_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push)
			out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {out_q.gen, out_q.idx};
	assign m_axis_tuser = out_q.status;

endmodule
